// File: rtl/rlepd_pkg.sv
// Shared types and constants of the run-length pixel stream decoder.
`timescale 1ns / 1ps

package rlepd_pkg;

  // Default width of the pixel index counter.
  localparam int DEF_INDEX_BITS = 24;

  // Configuration register layout.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_BYTES_PER_PIXEL = 1'b0,
    REG_PIXEL_TOTAL     = 1'b1
  } cfg_reg_t;

  // Register reset values and the pixel size that carries alpha.
  localparam logic [2:0]  BPP_RESET   = 3'd3;
  localparam logic [2:0]  BPP_ALPHA   = 3'd4;
  localparam logic [23:0] TOTAL_RESET = 24'd1;

  // Byte positions within a pixel at which the pixel completes.
  localparam logic [1:0] LAST_POS_RGB  = 2'd2;
  localparam logic [1:0] LAST_POS_RGBA = 2'd3;

  // Packet and pixel assembly state, apart from the pixel index counter.
  typedef struct packed {
    logic        expect_header;
    logic        packet_is_run;
    logic [7:0]  pixels_left;
    logic [1:0]  byte_pos;
    logic [31:0] pixel_bytes;
  } rlepd_state_t;

  // One decoded pixel word.
  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic [23:0] first_index;
    logic        image_done;
    logic        overrun;
  } rlepd_result_t;

endpackage

// File: rtl/rle_pixel_run_decoder.sv
// Top level of the run-length pixel stream decoder with its register port.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid/in_ready    in_data_byte
//   out_      output     out_valid/out_ready  out_red .. out_overrun
//   config    input      psel/penable/pready  paddr, pwdata, prdata
//
// Bytes pass an input register, results an output register; one byte per cycle unless stalled.
// The sustained rate is set by the single update of the packet state per byte.
// The input register frees whenever the output register is empty or being taken.
// Reset (rst_n low, synchronous) clears the decoder to await a header of a new image.
// Register writes take effect at once and do not disturb the decoding state.
`timescale 1ns / 1ps

module rle_pixel_run_decoder import rlepd_pkg::*; #(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Coded byte stream
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  // Decoded pixel words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_alpha,
  output logic [7:0]            out_repeat_count,
  output logic [23:0]           out_first_index,
  output logic                  out_image_done,
  output logic                  out_overrun,
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [2:0]            bpp_r;
  logic [23:0]           total_r;
  logic                  cfg_write;

  logic                  in_valid_r;
  logic                  in_valid_nxt;
  logic [7:0]            in_byte_r;
  logic                  fire;

  rlepd_state_t          state_r;
  rlepd_state_t          state_nxt;
  logic [INDEX_BITS-1:0] pixels_done_r;
  logic [INDEX_BITS-1:0] pixels_done_nxt;
  logic                  emit;
  rlepd_result_t         step_result;

  logic                  out_valid_r;
  logic                  out_valid_nxt;
  rlepd_result_t         out_word_r;

  // Register port: always ready, word decoded by the register index bit.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r   <= BPP_RESET;
      total_r <= TOTAL_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(paddr[2]))
        REG_BYTES_PER_PIXEL: bpp_r   <= pwdata[2:0];
        REG_PIXEL_TOTAL:     total_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[2]))
      REG_BYTES_PER_PIXEL: prdata = {29'd0, bpp_r};
      REG_PIXEL_TOTAL:     prdata = {8'd0, total_r};
      default:             prdata = '0;
    endcase
  end

  // The held byte is processed when the output register can take a word.
  assign fire         = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready     = !in_valid_r || fire;
  assign in_valid_nxt = (in_valid && in_ready) ? 1'b1 : (fire ? 1'b0 : in_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
    end
  end

  // Packet decoding for the held byte.
  rlepd_step #(
    .INDEX_BITS (INDEX_BITS)
  ) u_step (
    .state           (state_r),
    .pixels_done     (pixels_done_r),
    .data_byte       (in_byte_r),
    .bytes_per_pixel (bpp_r),
    .pixel_total     (total_r),
    .state_nxt       (state_nxt),
    .pixels_done_nxt (pixels_done_nxt),
    .emit            (emit),
    .result          (step_result)
  );

  // Decoder state advances once per processed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.expect_header <= 1'b1;
      state_r.packet_is_run <= 1'b0;
      state_r.pixels_left   <= 8'd0;
      state_r.byte_pos      <= 2'd0;
      state_r.pixel_bytes   <= 32'd0;
      pixels_done_r         <= '0;
    end else if (fire) begin
      state_r       <= state_nxt;
      pixels_done_r <= pixels_done_nxt;
    end
  end

  // Output register holds a finished word until it is taken.
  assign out_valid_nxt = (fire && emit) ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_word_r <= step_result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_word_r.red;
  assign out_green        = out_word_r.green;
  assign out_blue         = out_word_r.blue;
  assign out_alpha        = out_word_r.alpha;
  assign out_repeat_count = out_word_r.repeat_count;
  assign out_first_index  = out_word_r.first_index;
  assign out_image_done   = out_word_r.image_done;
  assign out_overrun      = out_word_r.overrun;

endmodule

// File: rtl/rlepd_step.sv
// Next-state and result logic for one byte of the coded stream.
`timescale 1ns / 1ps

module rlepd_step import rlepd_pkg::*; #(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  rlepd_state_t            state,
  input  logic [INDEX_BITS-1:0]   pixels_done,
  input  logic [7:0]              data_byte,
  input  logic [2:0]              bytes_per_pixel,
  input  logic [23:0]             pixel_total,
  output rlepd_state_t            state_nxt,
  output logic [INDEX_BITS-1:0]   pixels_done_nxt,
  output logic                    emit,
  output rlepd_result_t           result
);

  // Comparison width covers both the index counter and the 24-bit total.
  localparam int CMP_W = (INDEX_BITS > 24) ? INDEX_BITS : 24;
  localparam logic [CMP_W-1:0] IDX_MASK = CMP_W'((64'd1 << INDEX_BITS) - 64'd1);

  logic              size_is_four;
  logic              pixel_complete;
  logic [31:0]       merged_bytes;
  logic [CMP_W-1:0]  total_masked;
  logic [CMP_W-1:0]  total_eff;
  logic [CMP_W-1:0]  done_ext;
  logic [CMP_W-1:0]  avail;
  logic [CMP_W-1:0]  left_ext;
  logic [CMP_W-1:0]  count_ext;
  logic [7:0]        left_eff;
  logic [7:0]        count_raw;
  logic [7:0]        count;
  logic              image_done;
  logic              overrun;

  // Place the new byte into the pixel word and see whether the pixel is whole.
  assign size_is_four   = (bytes_per_pixel == BPP_ALPHA);
  assign merged_bytes   = state.pixel_bytes | ({24'd0, data_byte} << {state.byte_pos, 3'b000});
  assign pixel_complete = size_is_four ? (state.byte_pos == LAST_POS_RGBA)
                                       : (state.byte_pos >= LAST_POS_RGB);

  // Pixels still allowed before the image total is reached.
  assign total_masked = CMP_W'(pixel_total) & IDX_MASK;
  assign total_eff    = (total_masked == '0) ? CMP_W'(1) : total_masked;
  assign done_ext     = CMP_W'(pixels_done);
  assign avail        = (total_eff > done_ext) ? (total_eff - done_ext) : '0;

  // Repeat count of this pixel, clipped to what the image still has room for.
  assign left_eff   = (state.pixels_left == 8'd0) ? 8'd1 : state.pixels_left;
  assign count_raw  = state.packet_is_run ? left_eff : 8'd1;
  assign left_ext   = CMP_W'(left_eff);
  assign count      = (CMP_W'(count_raw) > avail) ? avail[7:0] : count_raw;
  assign count_ext  = CMP_W'(count);
  assign overrun    = (left_ext > avail);
  assign image_done = (count_ext >= avail);

  always_comb begin
    state_nxt       = state;
    pixels_done_nxt = pixels_done;
    emit            = 1'b0;
    result          = '0;
    if (state.expect_header) begin
      // A header sets up a raw or a run packet; both lengths are low seven bits plus one.
      state_nxt.packet_is_run = data_byte[7];
      state_nxt.pixels_left   = {1'b0, data_byte[6:0]} + 8'd1;
      state_nxt.expect_header = 1'b0;
      state_nxt.byte_pos      = 2'd0;
      state_nxt.pixel_bytes   = 32'd0;
    end else if (!pixel_complete) begin
      state_nxt.pixel_bytes = merged_bytes;
      state_nxt.byte_pos    = state.byte_pos + 2'd1;
    end else begin
      // A whole pixel: report it and advance the packet and image counters, or clear them when the image is done.
      emit                = 1'b1;
      result.red          = merged_bytes[23:16];
      result.green        = merged_bytes[15:8];
      result.blue         = merged_bytes[7:0];
      result.alpha        = size_is_four ? merged_bytes[31:24] : 8'd0;
      result.repeat_count = count;
      result.first_index  = done_ext[23:0];
      result.image_done   = image_done;
      result.overrun      = overrun;
      state_nxt.byte_pos    = 2'd0;
      state_nxt.pixel_bytes = 32'd0;
      if (image_done) begin
        pixels_done_nxt         = '0;
        state_nxt.pixels_left   = 8'd0;
        state_nxt.expect_header = 1'b1;
      end else begin
        pixels_done_nxt       = pixels_done + INDEX_BITS'(count);
        state_nxt.pixels_left = left_eff - count_raw;
        if (left_eff == count_raw) begin
          state_nxt.expect_header = 1'b1;
        end
      end
    end
  end

endmodule
